FILE: hdl/mrg8_pkg.sv
// ----------------------------------------------------------------------------
// mrg8_pkg
// Shared widths, coefficients and reset seeds of the order-8 recursive
// generator modulo 2^31-1.
// ----------------------------------------------------------------------------
`default_nettype none

package mrg8_pkg;

    localparam int HIST_DEPTH    = 8;
    localparam int VALUE_W       = 31;
    localparam int COUNT_W       = 7;
    localparam int PROD_W        = 2 * VALUE_W;
    localparam int PAIR_W        = PROD_W + 1;
    localparam int HALF_W        = PROD_W + 2;
    localparam int SUM_W         = HALF_W - VALUE_W + 2;
    localparam int MAX_BURST_DEF = 64;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [PROD_W-1:0]  prod_t;

    localparam value_t COEF [HIST_DEPTH] = '{
        31'd1089656042, 31'd1906537547, 31'd1764115693, 31'd1304127872,
        31'd189748160,  31'd1984088114, 31'd626062218,  31'd1927846343
    };

    localparam logic [63:0] SEED_WORD [HIST_DEPTH] = '{
        64'd97531,
        64'd4525455822575795487,
        64'd4344602724667842419,
        64'd6476166431153771575,
        64'd586183196364871339,
        64'd7505285344278696207,
        64'd3044147933607407779,
        64'd2916917746092927399
    };

    // Newest seed is taken as is, the others from the upper word.
    function automatic value_t seed_f(input int idx);
        value_t seed;
        if (idx == 0) begin
            seed = SEED_WORD[idx][VALUE_W-1:0];
        end else begin
            seed = SEED_WORD[idx][32+VALUE_W-1:32];
        end
        return seed;
    endfunction

    typedef struct packed {
        logic   shift;
        value_t din;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/mrg8_cell.sv
// ----------------------------------------------------------------------------
// mrg8_cell
// One history word of the generator with its coefficient product. Shifts
// its word to the next cell and registers coefficient times word.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg8_cell
    import mrg8_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_ctl_t ctl_i,
    input  wire value_t    coef_i,
    input  wire value_t    seed_i,
    output value_t         hist_o,
    output prod_t          prod_o
);

    value_t hist_reg;
    value_t hist_next;
    prod_t  prod_reg;
    prod_t  prod_next;

    always_comb begin
        hist_next = ctl_i.shift ? ctl_i.din : hist_reg;
        prod_next = PROD_W'(hist_reg) * PROD_W'(coef_i);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= seed_i;
        end else begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign hist_o = hist_reg;
    assign prod_o = prod_reg;

endmodule

`default_nettype wire

FILE: hdl/mrg8_reduce.sv
// ----------------------------------------------------------------------------
// mrg8_reduce
// Registered adder tree over the cell products, then the two folds of the
// half-sums and of the total modulo 2^31-1.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg8_reduce
    import mrg8_pkg::*;
(
    input  wire logic  aclk,
    input  wire prod_t prod_i [HIST_DEPTH],
    output value_t     value_o
);

    localparam int PAIRS = HIST_DEPTH / 2;

    logic [PAIR_W-1:0] pair_reg [PAIRS];
    logic [HALF_W-1:0] lo_reg;
    logic [HALF_W-1:0] hi_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    value_t            fold;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PAIRS; i++) begin
            pair_reg[i] <= PAIR_W'(prod_i[2*i]) + PAIR_W'(prod_i[2*i+1]);
        end
        lo_reg  <= HALF_W'(pair_reg[0]) + HALF_W'(pair_reg[1]);
        hi_reg  <= HALF_W'(pair_reg[2]) + HALF_W'(pair_reg[3]);
        sum_reg <= sum_next;
    end

    always_comb begin
        sum_next = SUM_W'(lo_reg[VALUE_W-1:0]) + SUM_W'(lo_reg[HALF_W-1:VALUE_W])
                 + SUM_W'(hi_reg[VALUE_W-1:0]) + SUM_W'(hi_reg[HALF_W-1:VALUE_W]);
        fold     = sum_reg[VALUE_W-1:0] + VALUE_W'(sum_reg[SUM_W-1:VALUE_W]);
    end

    assign value_o = fold;

endmodule

`default_nettype wire

FILE: hdl/mrg8_random_generator.sv
// ----------------------------------------------------------------------------
// mrg8_random_generator
// Order-8 multiple recursive random generator modulo 2^31-1. A request
// transaction carries a count; the block returns that many 31-bit numbers,
// the final one with tlast set. A count of zero returns nothing, a count
// above MAX_BURST is cut to MAX_BURST. A request is taken only when the
// previous run has been produced. For each number, after the history row
// shifts, the cell products, the pair sums, the half-sums and the folded
// total each take one register stage; then the block emits the number and
// shifts it in, and only then starts on the next one. Back-pressure on the
// output stalls the run. The history returns to its fixed seeds on reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg8_random_generator
    import mrg8_pkg::*;
#(
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [6:0] count
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [30:0] value
    output logic             m_tlast
);

    localparam int REM_W  = $clog2(MAX_BURST + 1);
    localparam int WAIT_N = 4;
    localparam int WAIT_W = $clog2(WAIT_N);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [REM_W-1:0]   remaining_reg;
    logic [REM_W-1:0]   remaining_next;
    logic [WAIT_W-1:0]  wait_reg;
    logic [WAIT_W-1:0]  wait_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    value_t             out_value_reg;
    value_t             out_value_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic [COUNT_W-1:0] count;
    logic               shift;
    value_t             new_value;
    value_t             hist [HIST_DEPTH];
    prod_t              prod [HIST_DEPTH];
    cell_ctl_t          ctl  [HIST_DEPTH];

    assign count = s_tdata[COUNT_W-1:0];

    genvar g;
    generate
        for (g = 0; g < HIST_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign ctl[g] = '{shift: shift, din: new_value};
            end else begin : g_tail
                assign ctl[g] = '{shift: shift, din: hist[g-1]};
            end
            mrg8_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl_i   (ctl[g]),
                .coef_i  (COEF[g]),
                .seed_i  (seed_f(g)),
                .hist_o  (hist[g]),
                .prod_o  (prod[g])
            );
        end
    endgenerate

    mrg8_reduce u_reduce (
        .aclk    (aclk),
        .prod_i  (prod),
        .value_o (new_value)
    );

    always_comb begin
        state_next     = state_reg;
        remaining_next = remaining_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        shift          = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && count != '0) begin
                    remaining_next = (COUNT_W'(MAX_BURST) < count) ?
                                     REM_W'(MAX_BURST) : REM_W'(count);
                    wait_next      = '0;
                    state_next     = ST_WAIT;
                end
            end
            ST_WAIT: begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == WAIT_W'(WAIT_N - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    shift          = 1'b1;
                    out_valid_next = 1'b1;
                    out_value_next = new_value;
                    out_last_next  = (remaining_reg == REM_W'(1));
                    remaining_next = remaining_reg - 1'b1;
                    wait_next      = '0;
                    state_next     = (remaining_reg == REM_W'(1)) ? ST_IDLE : ST_WAIT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            remaining_reg <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_value_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: hdl/mrg8_checker.sv
// ----------------------------------------------------------------------------
// mrg8_checker
// Port-level checks of the generator: output hold under back-pressure,
// request acceptance only between runs, clean output after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg8_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[6:0] != 7'd0 |=> !s_tready)
        else $error("request taken while a run is starting");

    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken in the middle of a run");

    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid straight after reset");

endmodule

bind mrg8_random_generator mrg8_checker u_mrg8_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
